// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int          CAP_BITS  = 4;
    localparam logic [3:0]  CAP_RESET = 4'd8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    // Flags that travel with a lookup request along the row of cells.
    typedef struct packed {
        logic active;
        logic found;
        logic free_found;
        logic have_max;
    } t_scan_flags;

    // Update command broadcast to every cell for one cycle.
    typedef struct packed {
        logic en;
        logic write_key;
        logic write_value;
        logic set_valid;
        logic age_all;
    } t_upd_ctl;

endpackage

// ===== hdl/lru_key_value_store.sv =====
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+-------------------------------
// input     | in        | i_in_valid / o_in_stall  | i_operation, i_key, i_value
// output    | out       | o_out_valid / i_out_stall| o_hit, o_read_value
// config    | in        | i_cfg_valid / o_cfg_ready| i_cfg_capacity
//
// The lookup walks the row of cells one cell per cycle, then the decide step
// broadcasts the update to all cells. Reset (i_rst_n low, synchronous) clears
// all valid bits and ranks and sets the capacity to eight. A finished result
// waits in the output register; a stalled output holds the decide step, and
// the next request is taken only after it.
module lru_key_value_store #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [31:0] o_read_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_capacity
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkv_pkg::CAP_BITS) ? CNT_W : lkv_pkg::CAP_BITS;

    lkv_pkg::t_state       r_state;
    lkv_pkg::t_state       n_state;
    logic [3:0]            r_capacity;
    logic                  r_start;
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [31:0]           r_out_value;

    // Scan result captured from the end of the row.
    logic                  r_found;
    logic [CNT_W-1:0]      r_occ;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_hit_rank;
    logic [VALUE_BITS-1:0] r_hit_value;
    logic [IDX_W-1:0]      r_free_idx;
    logic [IDX_W-1:0]      r_max_idx;
    logic [IDX_W-1:0]      r_max_rank;

    lkv_pkg::t_scan_flags  c_flags     [0:MAX_ENTRIES];
    logic [CNT_W-1:0]      c_occ       [0:MAX_ENTRIES];
    logic [IDX_W-1:0]      c_hit_idx   [0:MAX_ENTRIES];
    logic [IDX_W-1:0]      c_hit_rank  [0:MAX_ENTRIES];
    logic [VALUE_BITS-1:0] c_hit_value [0:MAX_ENTRIES];
    logic [IDX_W-1:0]      c_free_idx  [0:MAX_ENTRIES];
    logic [IDX_W-1:0]      c_max_idx   [0:MAX_ENTRIES];
    logic [IDX_W-1:0]      c_max_rank  [0:MAX_ENTRIES];

    lkv_pkg::t_upd_ctl     d_upd;
    lkv_pkg::t_upd_ctl     upd;
    logic [IDX_W-1:0]      d_slot;
    logic [IDX_W-1:0]      d_thresh;
    logic                  in_accept;
    logic                  out_free;
    logic                  load_out;
    logic                  is_full;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic [CMP_W-1:0]      max_ext;

    assign c_flags[0]     = '{active: r_start, found: 1'b0, free_found: 1'b0,
                              have_max: 1'b0};
    assign c_occ[0]       = '0;
    assign c_hit_idx[0]   = '0;
    assign c_hit_rank[0]  = '0;
    assign c_hit_value[0] = '0;
    assign c_free_idx[0]  = '0;
    assign c_max_idx[0]   = '0;
    assign c_max_rank[0]  = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .KEY_BITS    (KEY_BITS),
            .VALUE_BITS  (VALUE_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_req_key    (r_key),
            .i_req_value  (r_value),
            .i_flags      (c_flags[g]),
            .i_occ        (c_occ[g]),
            .i_hit_idx    (c_hit_idx[g]),
            .i_hit_rank   (c_hit_rank[g]),
            .i_hit_value  (c_hit_value[g]),
            .i_free_idx   (c_free_idx[g]),
            .i_max_idx    (c_max_idx[g]),
            .i_max_rank   (c_max_rank[g]),
            .o_flags      (c_flags[g+1]),
            .o_occ        (c_occ[g+1]),
            .o_hit_idx    (c_hit_idx[g+1]),
            .o_hit_rank   (c_hit_rank[g+1]),
            .o_hit_value  (c_hit_value[g+1]),
            .o_free_idx   (c_free_idx[g+1]),
            .o_max_idx    (c_max_idx[g+1]),
            .o_max_rank   (c_max_rank[g+1]),
            .i_upd        (upd),
            .i_upd_slot   (d_slot),
            .i_upd_thresh (d_thresh)
        );
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Capacity zero acts as one; anything above the entry count acts as full size.
    assign cap_ext = CMP_W'(r_capacity);
    assign max_ext = CMP_W'(MAX_ENTRIES);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > max_ext) begin
            eff_cap = max_ext;
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign is_full = (CMP_W'(r_occ) >= eff_cap);

    always_comb begin
        d_upd    = '0;
        d_slot   = r_hit_idx;
        d_thresh = r_hit_rank;
        if (r_found) begin
            d_upd.en          = 1'b1;
            d_upd.write_value = (r_op == lkv_pkg::OP_PUT);
        end else if (r_op == lkv_pkg::OP_PUT) begin
            d_upd.en          = 1'b1;
            d_upd.write_key   = 1'b1;
            d_upd.write_value = 1'b1;
            if (is_full) begin
                d_slot   = r_max_idx;
                d_thresh = r_max_rank;
            end else begin
                d_slot          = r_free_idx;
                d_upd.set_valid = 1'b1;
                d_upd.age_all   = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (c_flags[MAX_ENTRIES].active) begin
                    n_state = lkv_pkg::ST_DECIDE;
                end
            end
            lkv_pkg::ST_DECIDE: begin
                if (out_free) begin
                    n_state = lkv_pkg::ST_IDLE;
                end
            end
            default: n_state = lkv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        upd        = '0;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            lkv_pkg::ST_SCAN: begin
                o_in_stall = 1'b1;
            end
            lkv_pkg::ST_DECIDE: begin
                load_out = out_free;
                if (out_free) begin
                    upd = d_upd;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkv_pkg::ST_IDLE;
            r_capacity  <= lkv_pkg::CAP_RESET;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= in_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_key   <= KEY_BITS'(i_key);
            r_value <= VALUE_BITS'(i_value);
        end
        if ((r_state == lkv_pkg::ST_SCAN) && c_flags[MAX_ENTRIES].active) begin
            r_found     <= c_flags[MAX_ENTRIES].found;
            r_occ       <= c_occ[MAX_ENTRIES];
            r_hit_idx   <= c_hit_idx[MAX_ENTRIES];
            r_hit_rank  <= c_hit_rank[MAX_ENTRIES];
            r_hit_value <= c_hit_value[MAX_ENTRIES];
            r_free_idx  <= c_free_idx[MAX_ENTRIES];
            r_max_idx   <= c_max_idx[MAX_ENTRIES];
            r_max_rank  <= c_max_rank[MAX_ENTRIES];
        end
        if (load_out) begin
            r_out_hit <= r_found;
            if (r_found && (r_op == lkv_pkg::OP_GET)) begin
                r_out_value <= 32'(r_hit_value);
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

endmodule

// ===== hdl/lkv_cell.sv =====
module lkv_cell #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [KEY_BITS-1:0]                   i_req_key,
    input  logic [VALUE_BITS-1:0]                 i_req_value,
    input  lkv_pkg::t_scan_flags                  i_flags,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]      i_occ,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_hit_idx,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_hit_rank,
    input  logic [VALUE_BITS-1:0]                 i_hit_value,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_free_idx,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_max_idx,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_max_rank,
    output lkv_pkg::t_scan_flags                  o_flags,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]      o_occ,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_hit_idx,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_hit_rank,
    output logic [VALUE_BITS-1:0]                 o_hit_value,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_free_idx,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_max_idx,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_max_rank,
    input  lkv_pkg::t_upd_ctl                     i_upd,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_upd_slot,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_upd_thresh
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // Entry held by this cell.
    logic                  r_valid;
    logic [IDX_W-1:0]      r_rank;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Scan stage register handed to the next cell.
    lkv_pkg::t_scan_flags  r_flags;
    logic [CNT_W-1:0]      r_occ;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_hit_rank;
    logic [VALUE_BITS-1:0] r_hit_value;
    logic [IDX_W-1:0]      r_free_idx;
    logic [IDX_W-1:0]      r_max_idx;
    logic [IDX_W-1:0]      r_max_rank;

    lkv_pkg::t_scan_flags  n_flags;
    logic [CNT_W-1:0]      n_occ;
    logic [IDX_W-1:0]      n_hit_idx;
    logic [IDX_W-1:0]      n_hit_rank;
    logic [VALUE_BITS-1:0] n_hit_value;
    logic [IDX_W-1:0]      n_free_idx;
    logic [IDX_W-1:0]      n_max_idx;
    logic [IDX_W-1:0]      n_max_rank;

    always_comb begin
        n_flags     = i_flags;
        n_occ       = i_occ;
        n_hit_idx   = i_hit_idx;
        n_hit_rank  = i_hit_rank;
        n_hit_value = i_hit_value;
        n_free_idx  = i_free_idx;
        n_max_idx   = i_max_idx;
        n_max_rank  = i_max_rank;
        if (i_flags.active && r_valid) begin
            n_occ = i_occ + CNT_W'(1);
            if (!i_flags.found && (r_key == i_req_key)) begin
                n_flags.found = 1'b1;
                n_hit_idx     = MY_IDX;
                n_hit_rank    = r_rank;
                n_hit_value   = r_value;
            end
            if (!i_flags.have_max || (r_rank > i_max_rank)) begin
                n_flags.have_max = 1'b1;
                n_max_idx        = MY_IDX;
                n_max_rank       = r_rank;
            end
        end else if (i_flags.active && !i_flags.free_found) begin
            n_flags.free_found = 1'b1;
            n_free_idx         = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_flags <= n_flags;
            if (i_upd.en) begin
                if (i_upd_slot == MY_IDX) begin
                    r_rank <= '0;
                    if (i_upd.set_valid) begin
                        r_valid <= 1'b1;
                    end
                end else if (r_valid) begin
                    // Entries newer than the slot (all on age_all) age by one.
                    if (i_upd.age_all || (r_rank < i_upd_thresh)) begin
                        r_rank <= r_rank + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_occ       <= n_occ;
        r_hit_idx   <= n_hit_idx;
        r_hit_rank  <= n_hit_rank;
        r_hit_value <= n_hit_value;
        r_free_idx  <= n_free_idx;
        r_max_idx   <= n_max_idx;
        r_max_rank  <= n_max_rank;
        if (i_upd.en && (i_upd_slot == MY_IDX)) begin
            if (i_upd.write_key) begin
                r_key <= i_req_key;
            end
            if (i_upd.write_value) begin
                r_value <= i_req_value;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_occ       = r_occ;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_rank  = r_hit_rank;
    assign o_hit_value = r_hit_value;
    assign o_free_idx  = r_free_idx;
    assign o_max_idx   = r_max_idx;
    assign o_max_rank  = r_max_rank;

endmodule
